[hdl/mpoc_pkg.sv]
// ============================================================================
// mpoc_pkg
// Shared sizes, register codes, types and helpers for the multi-pattern
// occurrence counter.
// ============================================================================
package mpoc_pkg;

    // Block sizing.
    localparam int NUM_PATTERNS    = 4;
    localparam int MAX_PATTERN_LEN = 8;
    localparam int COUNT_WIDTH     = 32;

    // Four pattern registers exist, so at most four patterns are tracked.
    localparam int NUM_SLOTS  = 4;
    localparam int NUM_ACTIVE = (NUM_PATTERNS < NUM_SLOTS) ? NUM_PATTERNS : NUM_SLOTS;
    localparam int HIST_BYTES = MAX_PATTERN_LEN - 1;

    // Field widths.
    localparam int SLOT_W     = 2;
    localparam int LEN_W      = 4;
    localparam int BYTE_W     = 8;
    localparam int CFG_W      = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int LENGTHS_W  = LEN_W * NUM_SLOTS;
    localparam int MATCH_W    = 32;

    // Result packing: pattern_index, match_count, count_saturated.
    localparam int RES_BITS    = SLOT_W + MATCH_W + 1;
    localparam int OUT_TDATA_W = ((RES_BITS + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - RES_BITS;

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
    localparam logic [LEN_W-1:0]       LEN_MAX = LEN_W'(MAX_PATTERN_LEN);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_A       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_B       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_C       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_D       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTHS = 3'd4;

    // Count of one pattern together with its saturation flag.
    typedef struct packed {
        logic [COUNT_WIDTH-1:0] count;
        logic                   sat;
    } tally_t;

    // Clips a counter value to the 32-bit result field.
    function automatic logic [MATCH_W-1:0] clip_count(input logic [COUNT_WIDTH-1:0] c);
        logic [63:0] wide;
        wide = 64'(c);
        if (wide > 64'h0000_0000_FFFF_FFFF) begin
            return '1;
        end
        return wide[MATCH_W-1:0];
    endfunction

endpackage

[hdl/mpoc_cell.sv]
// ============================================================================
// mpoc_cell
// One history byte of the shift chain with its valid flag and a byte compare
// against the expected byte of every pattern at this age.
// ============================================================================
module mpoc_cell import mpoc_pkg::*; (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            shift_en,
    input  logic                            clear,
    input  logic [BYTE_W-1:0]               byte_in,
    input  logic                            valid_in,
    input  logic [NUM_SLOTS-1:0][BYTE_W-1:0] expect_bytes,
    output logic [BYTE_W-1:0]               byte_out,
    output logic                            valid_out,
    output logic [NUM_SLOTS-1:0]            hit
);

    logic [BYTE_W-1:0] byte_reg;
    logic              valid_reg;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            byte_reg <= byte_in;
        end
    end

    // The whole chain empties after the final byte of a stream.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (shift_en) begin
            valid_reg <= clear ? 1'b0 : valid_in;
        end
    end

    always_comb begin
        for (int p = 0; p < NUM_SLOTS; p++) begin
            hit[p] = (byte_reg == expect_bytes[p]);
        end
    end

    assign byte_out  = byte_reg;
    assign valid_out = valid_reg;

endmodule

[hdl/mpoc_counter.sv]
// ============================================================================
// mpoc_counter
// Saturating occurrence counter of one pattern, cleared after each report.
// ============================================================================
module mpoc_counter import mpoc_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   inc,
    input  logic   clear,
    output tally_t tally
);

    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_upd;
    logic [COUNT_WIDTH-1:0] count_next;

    // The updated value includes the current byte, so a report taken on the
    // final byte already counts a match that ends on it.
    assign count_upd  = (inc && (count_reg != CNT_MAX)) ? count_reg + 1'b1 : count_reg;
    assign count_next = clear ? '0 : count_upd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    assign tally.count = count_upd;
    assign tally.sat   = (count_upd == CNT_MAX);

endmodule

[hdl/mpoc_report.sv]
// ============================================================================
// mpoc_report
// Holds a snapshot of all pattern counts and sends one result transaction per
// pattern on the output stream.
// ============================================================================
module mpoc_report import mpoc_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   load,
    input  tally_t                 tallies [NUM_SLOTS],
    input  logic                   m_tready,
    output logic                   m_tvalid,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tlast,
    output logic                   free
);

    tally_t            bank_reg [NUM_SLOTS];
    logic              valid_reg;
    logic              valid_next;
    logic [SLOT_W-1:0] idx_reg;
    logic [SLOT_W-1:0] idx_next;
    logic              last;
    tally_t            cur;

    assign cur  = bank_reg[idx_reg];
    assign last = (idx_reg == SLOT_W'(NUM_ACTIVE - 1));

    always_ff @(posedge aclk) begin
        if (load) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                bank_reg[i] <= tallies[i];
            end
        end
    end

    always_comb begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load) begin
            valid_next = 1'b1;
            idx_next   = '0;
        end else if (valid_reg && m_tready) begin
            if (last) begin
                valid_next = 1'b0;
                idx_next   = '0;
            end else begin
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    // A new snapshot may land while the last result of the previous one leaves.
    assign free = !valid_reg || (m_tready && last);

    assign m_tvalid = valid_reg;
    assign m_tlast  = last;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, cur.sat, clip_count(cur.count), idx_reg};

endmodule

[hdl/multi_pattern_occurrence_counter.sv]
// ============================================================================
// multi_pattern_occurrence_counter
// Counts every overlapping occurrence of up to four configured byte patterns
// in a byte stream and reports one count per pattern at the end of a stream.
// ============================================================================
//
// Channel     Direction  tdata (lowest bit first)                     tlast
// ----------  ---------  -------------------------------------------  -------------
// s_ (input)  in         [7:0] data_byte                              end_of_stream
// m_ (result) out        [1:0] pattern_index, [33:2] match_count,     last_result
//                        [34] count_saturated, [39:35] zero
// cfg_        in         cfg_index selects the register, cfg_wdata    -
//
// One input transaction is taken per cycle while no final byte waits. Its
// byte is compared against all patterns in the same cycle it is accepted, so
// a stream runs at one byte per clock with no gaps but for its final byte. A
// transaction with tlast set snapshots the counts into the report bank; the
// first result is presented the cycle after, and the four results leave one
// per cycle while m_tready is high. The bank is the only report buffer, so a
// byte with tlast set waits while an earlier report is still being sent; it
// can be taken at the edge that takes that report's last result.
// Ordinary bytes are never held back by the result side.
// Reset (aresetn low at a clock edge) clears the history, the counters, the
// pending report and all configuration registers.
//
module multi_pattern_occurrence_counter import mpoc_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,

    // Input stream.
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [BYTE_W-1:0]      s_tdata,   // [7:0] data_byte
    input  logic                   s_tlast,   // end_of_stream

    // Result stream.
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [1:0] pattern_index, [33:2] match_count,
                                              // [34] count_saturated, [39:35] zero
    output logic                   m_tlast,   // last_result

    // Configuration write port.
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]       cfg_wdata
);

    // ------------------------------------------------------------------------
    // Configuration registers. The patterns hold their first byte in the
    // lowest byte lane; a length of zero disables a pattern.
    // ------------------------------------------------------------------------
    logic [CFG_W-1:0]     pattern_reg [NUM_SLOTS];
    logic [LENGTHS_W-1:0] lengths_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int p = 0; p < NUM_SLOTS; p++) begin
                pattern_reg[p] <= '0;
            end
            lengths_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index) inside
                REG_PATTERN_A, REG_PATTERN_B, REG_PATTERN_C, REG_PATTERN_D: begin
                    pattern_reg[cfg_index[SLOT_W-1:0]] <= cfg_wdata;
                end
                REG_PATTERN_LENGTHS: begin
                    lengths_reg <= cfg_wdata[LENGTHS_W-1:0];
                end
                default: begin
                    // Writes to unknown registers are dropped.
                end
            endcase
        end
    end

    // Effective lengths, clipped to the longest supported pattern.
    logic [LEN_W-1:0] len_eff [NUM_SLOTS];

    always_comb begin
        for (int p = 0; p < NUM_SLOTS; p++) begin
            len_eff[p] = (lengths_reg[p*LEN_W +: LEN_W] > LEN_MAX)
                         ? LEN_MAX : lengths_reg[p*LEN_W +: LEN_W];
        end
    end

    // ------------------------------------------------------------------------
    // Expected bytes. Age 0 is the incoming byte and age k the byte seen k
    // transactions earlier. A pattern of length L ends on the incoming byte
    // when its byte L-1-k equals the byte of age k for every k below L.
    // ------------------------------------------------------------------------
    logic [NUM_SLOTS-1:0][BYTE_W-1:0] expect_bytes [MAX_PATTERN_LEN];

    always_comb begin
        logic [LEN_W-1:0] pos;
        for (int a = 0; a < MAX_PATTERN_LEN; a++) begin
            for (int p = 0; p < NUM_SLOTS; p++) begin
                pos = len_eff[p] - LEN_W'(a) - 1'b1;
                expect_bytes[a][p] = pattern_reg[p][{pos[2:0], 3'b000} +: BYTE_W];
            end
        end
    end

    // ------------------------------------------------------------------------
    // Handshake. Only a final byte needs the report bank, so only a final
    // byte waits for it.
    // ------------------------------------------------------------------------
    logic rpt_free;
    logic accept;
    logic eos_accept;

    assign s_tready   = rpt_free || !s_tlast;
    assign accept     = s_tvalid && s_tready;
    assign eos_accept = accept && s_tlast;

    // ------------------------------------------------------------------------
    // History chain. Each cell holds one past byte and its valid flag and
    // passes both to its older neighbor on every accepted transaction.
    // ------------------------------------------------------------------------
    logic [BYTE_W-1:0]    chain_byte  [MAX_PATTERN_LEN];
    logic                 chain_valid [MAX_PATTERN_LEN];
    logic [NUM_SLOTS-1:0] chain_hit   [MAX_PATTERN_LEN];

    assign chain_byte[0]  = s_tdata;
    assign chain_valid[0] = 1'b1;

    always_comb begin
        for (int p = 0; p < NUM_SLOTS; p++) begin
            chain_hit[0][p] = (s_tdata == expect_bytes[0][p]);
        end
    end

    for (genvar k = 1; k <= HIST_BYTES; k++) begin : g_cell
        mpoc_cell u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .shift_en     (accept),
            .clear        (s_tlast),
            .byte_in      (chain_byte[k-1]),
            .valid_in     (chain_valid[k-1]),
            .expect_bytes (expect_bytes[k]),
            .byte_out     (chain_byte[k]),
            .valid_out    (chain_valid[k]),
            .hit          (chain_hit[k])
        );
    end

    // ------------------------------------------------------------------------
    // Match per pattern: every byte inside the pattern's span must be valid
    // and equal, so a pattern longer than the stream so far never matches.
    // ------------------------------------------------------------------------
    logic [NUM_ACTIVE-1:0] match;

    always_comb begin
        for (int p = 0; p < NUM_ACTIVE; p++) begin
            match[p] = (len_eff[p] != '0);
            for (int a = 0; a < MAX_PATTERN_LEN; a++) begin
                if (LEN_W'(a) < len_eff[p]) begin
                    match[p] = match[p] && chain_hit[a][p] && chain_valid[a];
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Counters and report.
    // ------------------------------------------------------------------------
    tally_t tallies [NUM_SLOTS];

    for (genvar p = 0; p < NUM_SLOTS; p++) begin : g_slot
        if (p < NUM_ACTIVE) begin : g_used
            mpoc_counter u_counter (
                .aclk    (aclk),
                .aresetn (aresetn),
                .inc     (accept && match[p]),
                .clear   (eos_accept),
                .tally   (tallies[p])
            );
        end else begin : g_unused
            assign tallies[p] = '0;
        end
    end

    mpoc_report u_report (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (eos_accept),
        .tallies  (tallies),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .free     (rpt_free)
    );

endmodule

[dv/tb_multi_pattern_occurrence_counter.sv]
// ============================================================================
// tb_multi_pattern_occurrence_counter
// Self-checking bench for the pattern occurrence counter. Byte streams are
// sent under a series of pattern setups. A predictor keeps its own history
// window and counters, and every count report is checked against it.
// ============================================================================
module tb_multi_pattern_occurrence_counter;
    import mpoc_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int IDLE_PCT      = 10;        // chance in a hundred of an idle cycle
    localparam int RANDOM_ITEMS  = 480;
    localparam int SETTLE_CYCLES = 8;         // report drain plus margin
    localparam int LIMIT_CYCLES  = 200_000;
    localparam int STEADY_FIRST  = 160;       // random-part window with no idling
    localparam int STEADY_LAST   = 300;

    // The highest index the write port can carry; everything above the
    // lengths register is unused and must be ignored by the block.
    localparam logic [CFG_IDX_W-1:0] REG_IDX_TOP = '1;

    // One expected count report.
    typedef struct {
        logic [SLOT_W-1:0]  index;
        logic [MATCH_W-1:0] count;
        logic               sat;
        logic               last;
    } count_report_t;

    // Predicts the count reports from the accepted bytes and holds them
    // until the block delivers them.
    class pattern_count_scoreboard;
        logic [CFG_W-1:0]        patterns [NUM_SLOTS];
        logic [LENGTHS_W-1:0]    lengths;
        logic [8*HIST_BYTES-1:0] history;
        int unsigned             fill;
        logic [COUNT_WIDTH-1:0]  counts [NUM_SLOTS];
        logic                    saturated [NUM_SLOTS];
        count_report_t           expected_reports [$];
        int unsigned             error_count;

        function new();
            foreach (patterns[i]) patterns[i] = '0;
            lengths     = '0;
            error_count = 0;
            clear_stream();
        endfunction

        function void clear_stream();
            history = '0;
            fill    = 0;
            foreach (counts[i]) begin
                counts[i]    = '0;
                saturated[i] = 1'b0;
            end
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
            case (idx)
                REG_PATTERN_A:       patterns[0] = value;
                REG_PATTERN_B:       patterns[1] = value;
                REG_PATTERN_C:       patterns[2] = value;
                REG_PATTERN_D:       patterns[3] = value;
                REG_PATTERN_LENGTHS: lengths = value[LENGTHS_W-1:0];
                default: ;
            endcase
        endfunction

        // Length fields above the maximum behave as the maximum.
        function int unsigned slot_length(int slot);
            int unsigned len;
            len = lengths[LEN_W*slot +: LEN_W];
            return (len > MAX_PATTERN_LEN) ? MAX_PATTERN_LEN : len;
        endfunction

        // The pattern's first byte lines up with the oldest byte of the
        // window's tail; the newest byte sits in the low lane.
        function bit window_hit(logic [8*MAX_PATTERN_LEN-1:0] window, int unsigned avail,
                                int slot);
            int unsigned len;
            len = slot_length(slot);
            if (len == 0 || len > avail) return 1'b0;
            for (int j = 0; j < len; j++) begin
                if (patterns[slot][8*j +: 8] != window[8*(len-1-j) +: 8]) return 1'b0;
            end
            return 1'b1;
        endfunction

        function void take_byte(logic [BYTE_W-1:0] b, logic eos);
            logic [8*MAX_PATTERN_LEN-1:0] window;
            int unsigned                  avail;
            logic [63:0]                  wide;
            count_report_t                rep;
            window = {history, b};
            avail  = fill + 1;
            for (int i = 0; i < NUM_ACTIVE; i++) begin
                if (window_hit(window, avail, i) && counts[i] != CNT_MAX) begin
                    counts[i] = counts[i] + 1'b1;
                    if (counts[i] == CNT_MAX) saturated[i] = 1'b1;
                end
            end
            history = window[8*HIST_BYTES-1:0];
            if (fill < HIST_BYTES) fill++;
            if (eos) begin
                for (int i = 0; i < NUM_ACTIVE; i++) begin
                    wide      = 64'(counts[i]);
                    rep.index = SLOT_W'(i);
                    rep.count = (wide > 64'hFFFF_FFFF) ? '1 : wide[MATCH_W-1:0];
                    rep.sat   = saturated[i];
                    rep.last  = (i == NUM_ACTIVE - 1);
                    expected_reports = {expected_reports, rep};
                end
                clear_stream();
            end
        endfunction

        task report(string what);
            error_count++;
            if (error_count <= 40) $display("MISMATCH: %s", what);
        endtask

        task check_report(logic [OUT_TDATA_W-1:0] tdata, logic tlast);
            count_report_t want;
            if (expected_reports.size() == 0) begin
                report($sformatf("result with no report pending, tdata %h", tdata));
                return;
            end
            want = expected_reports.pop_front();
            if (tdata[SLOT_W-1:0] !== want.index)
                report($sformatf("pattern_index %0d, expected %0d",
                                 tdata[SLOT_W-1:0], want.index));
            if (tdata[SLOT_W +: MATCH_W] !== want.count)
                report($sformatf("pattern %0d: match_count %0d, expected %0d",
                                 want.index, tdata[SLOT_W +: MATCH_W], want.count));
            if (tdata[SLOT_W+MATCH_W] !== want.sat)
                report($sformatf("pattern %0d: count_saturated %b, expected %b",
                                 want.index, tdata[SLOT_W+MATCH_W], want.sat));
            if (tlast !== want.last)
                report($sformatf("pattern %0d: last_result %b, expected %b",
                                 want.index, tlast, want.last));
        endtask

        task flush_check();
            if (expected_reports.size() != 0)
                report($sformatf("%0d count reports never arrived", expected_reports.size()));
        endtask
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [BYTE_W-1:0]      s_tdata;
    logic                   s_tlast;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_W-1:0]       cfg_wdata;

    pattern_count_scoreboard sb;
    int unsigned             items_sent = 0;
    bit                      steady     = 1'b0;   // suppresses idling on both sides

    multi_pattern_occurrence_counter u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    // The result side stalls now and then, except inside the steady stretch.
    always @(negedge aclk) begin
        m_tready <= steady || ($urandom_range(99, 0) >= IDLE_PCT);
    end

    // Every result transaction is checked against the oldest expected report.
    // Sampling at the rising edge sees the values the block presented before it.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_report(m_tdata, m_tlast);
    end

    // Byte values biased toward the ones that make patterns meet: NUL, all
    // ones and a tiny alphabet, with fully random bytes mixed in.
    function automatic logic [BYTE_W-1:0] pick_byte();
        case ($urandom_range(3, 0))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h61 + 8'($urandom_range(2, 0));
            default: return 8'($urandom);
        endcase
    endfunction

    // A quarter of the pattern words are fully random so every bit of the
    // write data toggles; the rest are built from the biased byte values.
    function automatic logic [CFG_W-1:0] pick_pattern();
        logic [CFG_W-1:0] w;
        if ($urandom_range(3, 0) == 0) return {$urandom, $urandom};
        for (int j = 0; j < CFG_W / 8; j++) w[8*j +: 8] = pick_byte();
        return w;
    endfunction

    // Mostly valid lengths, some disabled, some above the maximum.
    function automatic logic [LEN_W-1:0] pick_length();
        int r;
        r = $urandom_range(9, 0);
        if (r == 0) return LEN_W'($urandom_range((1 << LEN_W) - 1, MAX_PATTERN_LEN + 1));
        if (r == 1) return '0;
        return LEN_W'($urandom_range(MAX_PATTERN_LEN, 1));
    endfunction

    // Sends one byte as an input transaction and hands it to the predictor
    // once the block has taken it. Returns at the falling edge after the
    // handshake with s_tvalid still high, so back-to-back bytes need no
    // second assignment in the same time step.
    task automatic push_byte(input logic [BYTE_W-1:0] b, input logic eos);
        while (!steady && $urandom_range(99, 0) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eos;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.take_byte(b, eos);
        items_sent++;
        @(negedge aclk);
    endtask

    // Lets the block drain: every expected report has to arrive, then a few
    // more cycles pass before anything is reconfigured.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.expected_reports.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // One register write per cycle; the caller lowers the write enable.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        sb.write_reg(idx, value);
        @(negedge aclk);
    endtask

    // Loads all pattern registers and the lengths. The upper bits of the
    // lengths write carry junk that the block must drop. Writes to the unused
    // indexes, when asked for, come last so a block that wrongly takes them
    // would corrupt the setup.
    task automatic load_setup(input logic [CFG_W-1:0] pat [NUM_SLOTS],
                              input logic [LENGTHS_W-1:0] lens, input bit poke_unused);
        write_reg(REG_PATTERN_A, pat[0]);
        write_reg(REG_PATTERN_B, pat[1]);
        write_reg(REG_PATTERN_C, pat[2]);
        write_reg(REG_PATTERN_D, pat[3]);
        write_reg(REG_PATTERN_LENGTHS, {32'($urandom), 16'($urandom), lens});
        if (poke_unused) begin
            for (int k = int'(REG_PATTERN_LENGTHS) + 1; k <= int'(REG_IDX_TOP); k++)
                write_reg(CFG_IDX_W'(k), {$urandom, $urandom});
        end
        cfg_we <= 1'b0;
    endtask

    // Builds one stream of the given length. Most of it is copies of the
    // configured patterns, so counts actually climb and overlaps happen; the
    // rest is biased and fully random noise. A copy cut off at the end of the
    // stream leaves a broken occurrence that must not count. The last byte
    // carries end_of_stream.
    task automatic send_stream(input int unsigned len);
        logic [BYTE_W-1:0] stream_bytes [$];
        int                slot;
        int unsigned       plen;
        while (stream_bytes.size() < len) begin
            case ($urandom_range(9, 0))
                0, 1, 2, 3: begin
                    slot = $urandom_range(NUM_SLOTS - 1, 0);
                    plen = sb.slot_length(slot);
                    if (plen == 0) plen = $urandom_range(MAX_PATTERN_LEN, 1);
                    for (int j = 0; j < plen; j++)
                        stream_bytes = {stream_bytes, sb.patterns[slot][8*j +: 8]};
                end
                4, 5, 6: stream_bytes = {stream_bytes, pick_byte()};
                default: stream_bytes = {stream_bytes, 8'($urandom)};
            endcase
        end
        while (stream_bytes.size() > len) void'(stream_bytes.pop_back());
        foreach (stream_bytes[k]) push_byte(stream_bytes[k], k == len - 1);
    endtask

    initial begin
        logic [CFG_W-1:0]     pat [NUM_SLOTS];
        logic [LENGTHS_W-1:0] lens;
        int                   phase;
        int unsigned          random_start;
        int unsigned          len;

        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        sb        = new();

        // Synchronous reset, held low before the first stimulus.
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed setup: pattern A is "ab", B is three NUL bytes, C is eight
        // all-ones bytes with a length field above the maximum, and D holds
        // bytes but is disabled by a zero length.
        pat[0] = 64'h0000_0000_0000_6261;
        pat[1] = '0;
        pat[2] = '1;
        pat[3] = 64'h0123_4567_89AB_CDEF;
        lens   = {4'd0, 4'd15, 4'd3, 4'd2};
        load_setup(pat, lens, 1'b1);

        // Two NUL bytes: shorter than the NUL pattern, so the zeroed history
        // must not produce a match.
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b1);
        // "abab" followed by four NUL bytes: two hits on A and overlapping hits on B.
        push_byte(8'h61, 1'b0);
        push_byte(8'h62, 1'b0);
        push_byte(8'h61, 1'b0);
        push_byte(8'h62, 1'b0);
        repeat (3) push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b1);
        // Nine all-ones bytes: the clamped eight-byte pattern C hits twice.
        repeat (8) push_byte(8'hFF, 1'b0);
        push_byte(8'hFF, 1'b1);
        // A single-byte stream.
        push_byte(8'h62, 1'b1);
        settle();

        // Random part. The first phases pin the extreme setups: all-NUL
        // patterns of maximum length, all-ones patterns with every length
        // field at its top value, everything disabled, and one-byte patterns.
        phase        = 0;
        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                case (phase)
                    0: begin
                        pat[i]                  = '0;
                        lens[LEN_W*i +: LEN_W] = LEN_W'(MAX_PATTERN_LEN);
                    end
                    1: begin
                        pat[i]                  = '1;
                        lens[LEN_W*i +: LEN_W] = '1;
                    end
                    2: begin
                        pat[i]                  = pick_pattern();
                        lens[LEN_W*i +: LEN_W] = '0;
                    end
                    3: begin
                        pat[i]                  = pick_pattern();
                        lens[LEN_W*i +: LEN_W] = LEN_W'(1);
                    end
                    default: begin
                        pat[i]                  = pick_pattern();
                        lens[LEN_W*i +: LEN_W] = pick_length();
                    end
                endcase
            end
            load_setup(pat, lens, phase == 0 || $urandom_range(3, 0) == 0);

            repeat ($urandom_range(4, 1)) begin
                steady = (items_sent - random_start >= STEADY_FIRST) &&
                         (items_sent - random_start <  STEADY_LAST);
                // Mostly short streams, now and then a long one.
                len = ($urandom_range(7, 0) == 0) ? $urandom_range(48, 16)
                                                  : $urandom_range(15, 1);
                send_stream(len);
            end
            settle();
            phase++;
        end

        // All stimulus is in; give the block time to show anything extra.
        steady = 1'b0;
        while (sb.expected_reports.size() != 0) @(negedge aclk);
        repeat (4 * SETTLE_CYCLES) @(negedge aclk);
        sb.flush_check();
        if (sb.error_count == 0) begin
            $display("tb_multi_pattern_occurrence_counter: clean");
        end else begin
            $display("tb_multi_pattern_occurrence_counter: errors");
        end
        $finish;
    end

    // Guards against a hung handshake; far beyond the slowest correct run.
    initial begin
        #(LIMIT_CYCLES * 2 * CLK_HALF);
        $display("tb_multi_pattern_occurrence_counter: errors");
        $finish;
    end

endmodule
